FILE: rtl/atuv_pkg.sv
// Shared constants and types for the atlas tile UV calculator.
// No dependencies; the files that use it refer to it by scoped names.
package atuv_pkg;

   localparam int IDX_W     = 28;  // tile index width
   localparam int UV_W      = 17;  // unsigned Q1.16 result width
   localparam int CNT_W     = 15;  // column and row count width
   localparam int CSR_IDX_W = 3;

   localparam logic [UV_W-1:0] UV_MAX = 17'h1FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_WIDTH   = 3'd0,
      CSR_TILE_HEIGHT  = 3'd1,
      CSR_TILE_SPACING = 3'd2,
      CSR_ATLAS_MARGIN = 3'd3,
      CSR_ATLAS_WIDTH  = 3'd4,
      CSR_ATLAS_HEIGHT = 3'd5
   } csr_index_type;

endpackage

FILE: rtl/atuv_if.sv
// Valid/ready channel interfaces for tile requests and UV responses.
// Depends on atuv_pkg for field widths.
interface atuv_req_if;
   logic                       valid;
   logic                       ready;
   logic [atuv_pkg::IDX_W-1:0] tile_number;

   modport source (output valid, output tile_number, input ready);
   modport sink   (input valid, input tile_number, output ready);
endinterface

interface atuv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       valid_res;
   logic [atuv_pkg::UV_W-1:0]  u_low;
   logic [atuv_pkg::UV_W-1:0]  v_low;
   logic [atuv_pkg::UV_W-1:0]  u_high;
   logic [atuv_pkg::UV_W-1:0]  v_high;
   logic [atuv_pkg::CNT_W-1:0] column_count;
   logic [atuv_pkg::CNT_W-1:0] row_count;

   modport source (output valid, output valid_res, output u_low, output v_low,
                   output u_high, output v_high, output column_count,
                   output row_count, input ready);
   modport sink   (input valid, input valid_res, input u_low, input v_low,
                   input u_high, input v_high, input column_count,
                   input row_count, output ready);
endinterface

FILE: rtl/atuv_div_cell.sv
// One restoring-division cell: retires one quotient bit per lane and
// hands remainder, divisor, dividend, quotient and side data to the next cell.
module atuv_div_cell #(
   parameter int LANES = 1,
   parameter int DW    = 8,
   parameter int NW    = 8,
   parameter int SW    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [LANES-1:0][DW-1:0]   in_rem,
   input  logic [LANES-1:0][DW-1:0]   in_dvs,
   input  logic [LANES-1:0][NW-1:0]   in_num,
   input  logic [LANES-1:0][NW-1:0]   in_quo,
   input  logic [SW-1:0]              in_side,
   output logic                       out_vld,
   output logic [LANES-1:0][DW-1:0]   out_rem,
   output logic [LANES-1:0][DW-1:0]   out_dvs,
   output logic [LANES-1:0][NW-1:0]   out_num,
   output logic [LANES-1:0][NW-1:0]   out_quo,
   output logic [SW-1:0]              out_side
);

   logic                     vld_ff;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in, dvs_ff;
   logic [LANES-1:0][NW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [SW-1:0]            side_ff;

   always_comb begin
      logic [DW:0] wide;
      wide = '0;
      for (int l = 0; l < LANES; l++) begin
         wide      = {in_rem[l], in_num[l][NW-1]};
         num_in[l] = in_num[l] << 1;
         if (wide >= {1'b0, in_dvs[l]}) begin
            rem_in[l] = DW'(wide - {1'b0, in_dvs[l]});
            quo_in[l] = {in_quo[l][NW-2:0], 1'b1};
         end else begin
            rem_in[l] = wide[DW-1:0];
            quo_in[l] = {in_quo[l][NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvs_ff  <= in_dvs;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_dvs  = dvs_ff;
   assign out_num  = num_ff;
   assign out_quo  = quo_ff;
   assign out_side = side_ff;

endmodule

FILE: rtl/atuv_edge.sv
// Range check and pixel edges of a tile from its column and row.
// Two register stages: products, then edge sums. Uses atuv_pkg.
module atuv_edge #(
   parameter int CW = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [atuv_pkg::IDX_W-1:0] in_row,
   input  logic [CW-1:0]              in_col,
   input  logic [CW-1:0]              in_cols,
   input  logic [CW-1:0]              in_rows,
   input  logic [CW-1:0]              tile_width,
   input  logic [CW-1:0]              tile_height,
   input  logic [CW-1:0]              tile_spacing,
   input  logic [CW-1:0]              atlas_margin,
   output logic                       out_vld,
   output logic                       out_ok,
   output logic [CW-1:0]              out_cols,
   output logic [CW-1:0]              out_rows,
   output logic [CW-1:0]              out_x0,
   output logic [CW-1:0]              out_x1,
   output logic [CW-1:0]              out_y0,
   output logic [CW-1:0]              out_y1
);

   logic            e1_vld_ff, e2_vld_ff;
   logic            e1_ok_ff, e1_ok_in, e2_ok_ff;
   logic [CW-1:0]   e1_cols_ff, e1_rows_ff, e2_cols_ff, e2_rows_ff;
   logic [2*CW:0]   px_ff, px_in, py_ff, py_in;
   logic [CW:0]     pitch_w, pitch_h;
   logic [CW-1:0]   x0_in, x1_in, y0_in, y1_in;
   logic [CW-1:0]   x0_ff, x1_ff, y0_ff, y1_ff;

   // index past the grid shows up as a row beyond the row count
   assign e1_ok_in = (in_cols != '0) && (in_rows != '0) &&
                     (in_row < atuv_pkg::IDX_W'(in_rows));
   assign pitch_w  = {1'b0, tile_width} + {1'b0, tile_spacing};
   assign pitch_h  = {1'b0, tile_height} + {1'b0, tile_spacing};
   assign px_in    = (2*CW+1)'(in_col * pitch_w);
   assign py_in    = (2*CW+1)'(in_row[CW-1:0] * pitch_h);

   // edges fit the extent whenever the index is in range
   assign x0_in = px_ff[CW-1:0] + atlas_margin;
   assign y0_in = py_ff[CW-1:0] + atlas_margin;
   assign x1_in = x0_in + tile_width;
   assign y1_in = y0_in + tile_height;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
      end else if (en) begin
         e1_vld_ff <= in_vld;
         e2_vld_ff <= e1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ok_ff   <= e1_ok_in;
         e1_cols_ff <= in_cols;
         e1_rows_ff <= in_rows;
         px_ff      <= px_in;
         py_ff      <= py_in;
         e2_ok_ff   <= e1_ok_ff;
         e2_cols_ff <= e1_cols_ff;
         e2_rows_ff <= e1_rows_ff;
         x0_ff      <= x0_in;
         x1_ff      <= x1_in;
         y0_ff      <= y0_in;
         y1_ff      <= y1_in;
      end
   end

   assign out_vld  = e2_vld_ff;
   assign out_ok   = e2_ok_ff;
   assign out_cols = e2_cols_ff;
   assign out_rows = e2_rows_ff;
   assign out_x0   = x0_ff;
   assign out_x1   = x1_ff;
   assign out_y0   = y0_ff;
   assign out_y1   = y1_ff;

endmodule

FILE: rtl/atlas_tile_uv_calc.sv
// Atlas tile UV calculator top level: a tile index in, its UV rectangle out.
// Depends on atuv_pkg, atuv_if, atuv_div_cell and atuv_edge.
//
// Usage:
//   req_ch carries one tile_number per item; rsp_ch returns one item per
//   request, in order: valid_res, the four Q1.16 edges (V mirrored) and
//   the column and row counts of the current grid.
//   csr_we/csr_index/csr_wdata write the six geometry registers; write them
//   only while no item is in flight. Unknown indexes are dropped.
// Throughput: one item per cycle while not stalled; every stage is a division
//   cell or arithmetic stage that passes its item on each enabled cycle.
// Stages from acceptance to rsp valid: COORD_BITS+2 cells for the counts,
//   atuv_pkg::IDX_W cells for column/row, the product and edge-sum stages of
//   atuv_edge, COORD_BITS+1+UV_FRAC_BITS cells for the UV quotients.
// Reset: empties the pipe and restores 16x16 tiles on a 256x256 atlas.
// Stall: with rsp_ch.ready low and a result waiting, the whole pipe holds
//   and req_ch.ready drops; nothing is lost or repeated.
module atlas_tile_uv_calc #(
   parameter int COORD_BITS   = 14,
   parameter int UV_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   atuv_req_if.sink                       req_ch,
   atuv_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [atuv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_BITS:0]            csr_wdata
);

   localparam int CW   = COORD_BITS + 1;
   localparam int CNW  = CW + 1;                 // count division width
   localparam int IW   = atuv_pkg::IDX_W;
   localparam int UVW  = CW + UV_FRAC_BITS;      // UV dividend width
   localparam int CSW  = IW + 2;
   localparam int ISW  = 2 * CW;
   localparam int USW  = 2 * CW + 1;

   // ---------------- configuration ----------------
   logic [CW-1:0] tile_width_ff, tile_height_ff, tile_spacing_ff;
   logic [CW-1:0] atlas_margin_ff, atlas_width_ff, atlas_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff   <= CW'(16);
         tile_height_ff  <= CW'(16);
         tile_spacing_ff <= '0;
         atlas_margin_ff <= '0;
         atlas_width_ff  <= CW'(256);
         atlas_height_ff <= CW'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            atuv_pkg::CSR_TILE_WIDTH:   tile_width_ff   <= csr_wdata;
            atuv_pkg::CSR_TILE_HEIGHT:  tile_height_ff  <= csr_wdata;
            atuv_pkg::CSR_TILE_SPACING: tile_spacing_ff <= csr_wdata;
            atuv_pkg::CSR_ATLAS_MARGIN: atlas_margin_ff <= csr_wdata;
            atuv_pkg::CSR_ATLAS_WIDTH:  atlas_width_ff  <= csr_wdata;
            atuv_pkg::CSR_ATLAS_HEIGHT: atlas_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en && !reset;

   // ---------------- grid counts ----------------
   logic                     cnt_vld  [CNW+1];
   logic [1:0][CNW-1:0]      cnt_rem  [CNW+1];
   logic [1:0][CNW-1:0]      cnt_dvs  [CNW+1];
   logic [1:0][CNW-1:0]      cnt_num  [CNW+1];
   logic [1:0][CNW-1:0]      cnt_quo  [CNW+1];
   logic [CSW-1:0]           cnt_side [CNW+1];
   logic                     zero_col, zero_row;
   logic [CW-1:0]            room_w, room_h;

   assign room_w   = atlas_width_ff - atlas_margin_ff;
   assign room_h   = atlas_height_ff - atlas_margin_ff;
   assign zero_col = (tile_width_ff == '0) || (atlas_width_ff <= atlas_margin_ff) ||
                     (room_w < tile_width_ff);
   assign zero_row = (tile_height_ff == '0) || (atlas_height_ff <= atlas_margin_ff) ||
                     (room_h < tile_height_ff);

   assign cnt_vld[0]     = req_ch.valid;
   assign cnt_rem[0]     = '0;
   assign cnt_quo[0]     = '0;
   assign cnt_num[0][0]  = {1'b0, room_w} + {1'b0, tile_spacing_ff};
   assign cnt_num[0][1]  = {1'b0, room_h} + {1'b0, tile_spacing_ff};
   assign cnt_dvs[0][0]  = {1'b0, tile_width_ff} + {1'b0, tile_spacing_ff};
   assign cnt_dvs[0][1]  = {1'b0, tile_height_ff} + {1'b0, tile_spacing_ff};
   assign cnt_side[0]    = {zero_row, zero_col, req_ch.tile_number};

   for (genvar i = 0; i < CNW; i++) begin : g_cnt
      atuv_div_cell #(.LANES(2), .DW(CNW), .NW(CNW), .SW(CSW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (cnt_vld[i]),
         .in_rem  (cnt_rem[i]),
         .in_dvs  (cnt_dvs[i]),
         .in_num  (cnt_num[i]),
         .in_quo  (cnt_quo[i]),
         .in_side (cnt_side[i]),
         .out_vld (cnt_vld[i+1]),
         .out_rem (cnt_rem[i+1]),
         .out_dvs (cnt_dvs[i+1]),
         .out_num (cnt_num[i+1]),
         .out_quo (cnt_quo[i+1]),
         .out_side(cnt_side[i+1])
      );
   end

   logic [CW-1:0] cols, rows;
   assign cols = cnt_side[CNW][IW]   ? '0 : cnt_quo[CNW][0][CW-1:0];
   assign rows = cnt_side[CNW][IW+1] ? '0 : cnt_quo[CNW][1][CW-1:0];

   // ---------------- column and row ----------------
   logic                     idx_vld  [IW+1];
   logic [0:0][CW-1:0]       idx_rem  [IW+1];
   logic [0:0][CW-1:0]       idx_dvs  [IW+1];
   logic [0:0][IW-1:0]       idx_num  [IW+1];
   logic [0:0][IW-1:0]       idx_quo  [IW+1];
   logic [ISW-1:0]           idx_side [IW+1];

   assign idx_vld[0]     = cnt_vld[CNW];
   assign idx_rem[0]     = '0;
   assign idx_quo[0]     = '0;
   assign idx_num[0][0]  = cnt_side[CNW][IW-1:0];
   assign idx_dvs[0][0]  = cols;
   assign idx_side[0]    = {rows, cols};

   for (genvar i = 0; i < IW; i++) begin : g_idx
      atuv_div_cell #(.LANES(1), .DW(CW), .NW(IW), .SW(ISW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (idx_vld[i]),
         .in_rem  (idx_rem[i]),
         .in_dvs  (idx_dvs[i]),
         .in_num  (idx_num[i]),
         .in_quo  (idx_quo[i]),
         .in_side (idx_side[i]),
         .out_vld (idx_vld[i+1]),
         .out_rem (idx_rem[i+1]),
         .out_dvs (idx_dvs[i+1]),
         .out_num (idx_num[i+1]),
         .out_quo (idx_quo[i+1]),
         .out_side(idx_side[i+1])
      );
   end

   // ---------------- pixel edges ----------------
   logic          edg_vld, edg_ok;
   logic [CW-1:0] edg_cols, edg_rows, x0, x1, y0, y1;

   atuv_edge #(.CW(CW)) u_edge (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_vld       (idx_vld[IW]),
      .in_row       (idx_quo[IW][0]),
      .in_col       (idx_rem[IW][0]),
      .in_cols      (idx_side[IW][CW-1:0]),
      .in_rows      (idx_side[IW][ISW-1:CW]),
      .tile_width   (tile_width_ff),
      .tile_height  (tile_height_ff),
      .tile_spacing (tile_spacing_ff),
      .atlas_margin (atlas_margin_ff),
      .out_vld      (edg_vld),
      .out_ok       (edg_ok),
      .out_cols     (edg_cols),
      .out_rows     (edg_rows),
      .out_x0       (x0),
      .out_x1       (x1),
      .out_y0       (y0),
      .out_y1       (y1)
   );

   // ---------------- UV quotients ----------------
   // lanes: 0 u_low, 1 v_low, 2 u_high, 3 v_high
   logic                     uv_vld  [UVW+1];
   logic [3:0][CW-1:0]       uv_rem  [UVW+1];
   logic [3:0][CW-1:0]       uv_dvs  [UVW+1];
   logic [3:0][UVW-1:0]      uv_num  [UVW+1];
   logic [3:0][UVW-1:0]      uv_quo  [UVW+1];
   logic [USW-1:0]           uv_side [UVW+1];
   logic [CW-1:0]            v_lo_c, v_hi_c;

   assign v_lo_c = atlas_height_ff - y1;
   assign v_hi_c = atlas_height_ff - y0;

   assign uv_vld[0]    = edg_vld;
   assign uv_rem[0]    = '0;
   assign uv_quo[0]    = '0;
   assign uv_num[0][0] = {x0, {UV_FRAC_BITS{1'b0}}};
   assign uv_num[0][1] = {v_lo_c, {UV_FRAC_BITS{1'b0}}};
   assign uv_num[0][2] = {x1, {UV_FRAC_BITS{1'b0}}};
   assign uv_num[0][3] = {v_hi_c, {UV_FRAC_BITS{1'b0}}};
   assign uv_dvs[0][0] = atlas_width_ff;
   assign uv_dvs[0][1] = atlas_height_ff;
   assign uv_dvs[0][2] = atlas_width_ff;
   assign uv_dvs[0][3] = atlas_height_ff;
   assign uv_side[0]   = {edg_ok, edg_rows, edg_cols};

   for (genvar i = 0; i < UVW; i++) begin : g_uv
      atuv_div_cell #(.LANES(4), .DW(CW), .NW(UVW), .SW(USW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (uv_vld[i]),
         .in_rem  (uv_rem[i]),
         .in_dvs  (uv_dvs[i]),
         .in_num  (uv_num[i]),
         .in_quo  (uv_quo[i]),
         .in_side (uv_side[i]),
         .out_vld (uv_vld[i+1]),
         .out_rem (uv_rem[i+1]),
         .out_dvs (uv_dvs[i+1]),
         .out_num (uv_num[i+1]),
         .out_quo (uv_quo[i+1]),
         .out_side(uv_side[i+1])
      );
   end

   // ---------------- result ----------------
   logic                          res_ok;
   logic [3:0][atuv_pkg::UV_W-1:0] uv_sat;

   assign res_ok = uv_side[UVW][USW-1];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (!res_ok) begin
            uv_sat[l] = '0;
         end else if (uv_quo[UVW][l] > UVW'(atuv_pkg::UV_MAX)) begin
            uv_sat[l] = atuv_pkg::UV_MAX;
         end else begin
            uv_sat[l] = atuv_pkg::UV_W'(uv_quo[UVW][l]);
         end
      end
   end

   assign rsp_ch.valid        = uv_vld[UVW];
   assign rsp_ch.valid_res    = res_ok;
   assign rsp_ch.u_low        = uv_sat[0];
   assign rsp_ch.v_low        = uv_sat[1];
   assign rsp_ch.u_high       = uv_sat[2];
   assign rsp_ch.v_high       = uv_sat[3];
   assign rsp_ch.column_count = atuv_pkg::CNT_W'(uv_side[UVW][CW-1:0]);
   assign rsp_ch.row_count    = atuv_pkg::CNT_W'(uv_side[UVW][2*CW-1:CW]);

endmodule

FILE: sim/atuv_uv_checker.sv
// Checker for the atlas tile UV calculator: watches both channels and the register port,
// predicts each response and compares all its fields in one check. Depends on atuv_pkg.
`timescale 1ns / 100ps
module atuv_uv_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [atuv_pkg::IDX_W-1:0]     req_tile,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_valid_res,
   input  logic [atuv_pkg::UV_W-1:0]      rsp_u_low,
   input  logic [atuv_pkg::UV_W-1:0]      rsp_v_low,
   input  logic [atuv_pkg::UV_W-1:0]      rsp_u_high,
   input  logic [atuv_pkg::UV_W-1:0]      rsp_v_high,
   input  logic [atuv_pkg::CNT_W-1:0]     rsp_column_count,
   input  logic [atuv_pkg::CNT_W-1:0]     rsp_row_count,
   input  logic                           csr_we,
   input  logic [atuv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [14:0]                    csr_wdata,
   output int                             fail_count,
   output int                             pending,
   output int                             rsp_seen
);

   localparam int FRAC = 16;

   typedef struct packed {
      logic                           valid_res;
      logic [atuv_pkg::UV_W-1:0]      u_low;
      logic [atuv_pkg::UV_W-1:0]      v_low;
      logic [atuv_pkg::UV_W-1:0]      u_high;
      logic [atuv_pkg::UV_W-1:0]      v_high;
      logic [atuv_pkg::CNT_W-1:0]     column_count;
      logic [atuv_pkg::CNT_W-1:0]     row_count;
   } uv_rect_type;

   logic [14:0] tile_w, tile_h, spacing, margin, atlas_w, atlas_h;
   uv_rect_type rect_queue[$];

   function automatic longint tiles_on_axis(longint ext, longint sz, longint gap,
                                            longint border);
      if (sz == 0 || ext <= border || ext - border < sz) return 0;
      return (ext - border + gap) / (sz + gap);
   endfunction

   function automatic logic [atuv_pkg::UV_W-1:0] fixed_uv(longint coord, longint ext);
      longint q;
      if (ext == 0) return '0;
      q = (coord << FRAC) / ext;
      return (q > atuv_pkg::UV_MAX) ? atuv_pkg::UV_MAX : q[atuv_pkg::UV_W-1:0];
   endfunction

   function automatic uv_rect_type tile_rect(logic [atuv_pkg::IDX_W-1:0] tile);
      uv_rect_type r;
      longint      cols, rows, col, row, x0, y0, x1, y1;
      cols = tiles_on_axis(atlas_w, tile_w, spacing, margin);
      rows = tiles_on_axis(atlas_h, tile_h, spacing, margin);
      r = '0;
      r.column_count = cols[atuv_pkg::CNT_W-1:0];
      r.row_count = rows[atuv_pkg::CNT_W-1:0];
      if (cols == 0 || rows == 0 || longint'(tile) >= cols * rows) return r;
      col = longint'(tile) % cols;
      row = longint'(tile) / cols;
      x0 = margin + col * (tile_w + spacing);
      y0 = margin + row * (tile_h + spacing);
      x1 = x0 + tile_w;
      y1 = y0 + tile_h;
      r.valid_res = 1'b1;
      r.u_low  = fixed_uv(x0, atlas_w);
      r.v_low  = fixed_uv(atlas_h - y1, atlas_h);
      r.u_high = fixed_uv(x1, atlas_w);
      r.v_high = fixed_uv(atlas_h - y0, atlas_h);
      return r;
   endfunction

   assign pending = rect_queue.size();

   always @(posedge clock) begin
      uv_rect_type want, got;
      if (reset) begin
         tile_w <= 15'd16;
         tile_h <= 15'd16;
         spacing <= '0;
         margin <= '0;
         atlas_w <= 15'd256;
         atlas_h <= 15'd256;
         rect_queue.delete();
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               atuv_pkg::CSR_TILE_WIDTH: tile_w <= csr_wdata;
               atuv_pkg::CSR_TILE_HEIGHT: tile_h <= csr_wdata;
               atuv_pkg::CSR_TILE_SPACING: spacing <= csr_wdata;
               atuv_pkg::CSR_ATLAS_MARGIN: margin <= csr_wdata;
               atuv_pkg::CSR_ATLAS_WIDTH: atlas_w <= csr_wdata;
               atuv_pkg::CSR_ATLAS_HEIGHT: atlas_h <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) rect_queue.push_back(tile_rect(req_tile));
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            got = '{rsp_valid_res, rsp_u_low, rsp_v_low, rsp_u_high, rsp_v_high,
                    rsp_column_count, rsp_row_count};
            if (rect_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = rect_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: want v%0d u%h/%h v%h/%h c%0d r%0d, ",
                        "got v%0d u%h/%h v%h/%h c%0d r%0d",
                        want.valid_res, want.u_low, want.u_high, want.v_low,
                        want.v_high, want.column_count, want.row_count,
                        got.valid_res, got.u_low, got.u_high, got.v_low,
                        got.v_high, got.column_count, got.row_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: sim/atlas_tile_uv_calc_test.sv
// Testbench top for atlas_tile_uv_calc: clock, reset, register phases and request
// stimulus with random stalls. Depends on the DUT, atuv_pkg, atuv_if and atuv_uv_checker.
`timescale 1ns / 100ps
module atlas_tile_uv_calc_test;

   localparam int LATENCY = 77;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [atuv_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [14:0] csr_wdata = '0;
   logic        quiet = 1'b0;
   int          fail_count, pending, rsp_seen, sent;

   atuv_req_if req_ch ();
   atuv_rsp_if rsp_ch ();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.tile_number = '0;
      rsp_ch.ready = 1'b0;
   end

   always #5 clock = ~clock;

   atlas_tile_uv_calc u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   atuv_uv_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_tile(req_ch.tile_number),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_valid_res(rsp_ch.valid_res), .rsp_u_low(rsp_ch.u_low), .rsp_v_low(rsp_ch.v_low),
      .rsp_u_high(rsp_ch.u_high), .rsp_v_high(rsp_ch.v_high),
      .rsp_column_count(rsp_ch.column_count), .rsp_row_count(rsp_ch.row_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
   );

   // receiver stalls about 18% of cycles, except in quiet stretches
   always @(posedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 18);
   end

   task automatic write_reg(input atuv_pkg::csr_index_type idx, input logic [14:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_grid(input logic [14:0] tw, th, sp, mg, aw, ah);
      write_reg(atuv_pkg::CSR_TILE_WIDTH, tw);
      write_reg(atuv_pkg::CSR_TILE_HEIGHT, th);
      write_reg(atuv_pkg::CSR_TILE_SPACING, sp);
      write_reg(atuv_pkg::CSR_ATLAS_MARGIN, mg);
      write_reg(atuv_pkg::CSR_ATLAS_WIDTH, aw);
      write_reg(atuv_pkg::CSR_ATLAS_HEIGHT, ah);
   endtask

   // one item; idles at random before it unless quiet
   task automatic send_tile(input logic [atuv_pkg::IDX_W-1:0] tile);
      while (!quiet && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.tile_number <= tile;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [atuv_pkg::IDX_W-1:0] pick_tile(input int span);
      case ($urandom_range(9))
         0: return atuv_pkg::IDX_W'($urandom);
         1: return {atuv_pkg::IDX_W{1'b1}};
         2: return atuv_pkg::IDX_W'(span);
         default: return atuv_pkg::IDX_W'($urandom_range(span > 0 ? span - 1 : 0));
      endcase
   endfunction

   task automatic random_grid();
      logic [14:0] tw, th, sp, mg, aw, ah;
      case ($urandom_range(5))
         0: begin
            tw = 15'($urandom); th = 15'($urandom); sp = 15'($urandom);
            mg = 15'($urandom); aw = 15'($urandom); ah = 15'($urandom);
         end
         1: begin
            tw = 15'($urandom_range(16384, 32767)); th = 15'($urandom_range(1, 8));
            sp = 15'($urandom_range(32767)); mg = 15'($urandom_range(4));
            aw = 15'h7FFF; ah = 15'($urandom_range(1, 64));
         end
         default: begin
            tw = 15'($urandom_range(8)); th = 15'($urandom_range(8));
            sp = 15'($urandom_range(3)); mg = 15'($urandom_range(5));
            aw = 15'($urandom_range(128)); ah = 15'($urandom_range(128));
         end
      endcase
      set_grid(tw, th, sp, mg, aw, ah);
   endtask

   initial begin
      int span;
      sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset grid: 16x16 of 16-pixel tiles
      send_tile(0); send_tile(15); send_tile(16); send_tile(255); send_tile(256);
      send_tile({atuv_pkg::IDX_W{1'b1}});
      drain();
      // zero tile size, margin past the extent, tile larger than the room
      set_grid(0, 16, 0, 0, 256, 256); send_tile(0);
      drain();
      set_grid(16, 16, 0, 300, 256, 256); send_tile(0);
      drain();
      set_grid(200, 16, 0, 100, 256, 256); send_tile(0);
      drain();
      // zero-sized atlas, and all-ones registers above the stated range
      set_grid(1, 1, 0, 0, 0, 0); send_tile(0);
      drain();
      set_grid(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF); send_tile(0);
      drain();
      set_grid(15'h7FFF, 15'h7FFF, 15'h7FFF, 0, 15'h7FFF, 15'h7FFF); send_tile(0); send_tile(1);
      drain();
      // one-pixel tiles on a full-size atlas, spacing and margin
      set_grid(1, 1, 0, 0, 16384, 16384);
      send_tile(0); send_tile(16383); send_tile(28'd268435455);
      send_tile(28'(16384 * 16384 - 1));
      drain();
      set_grid(5, 7, 3, 2, 100, 90);
      send_tile(0); send_tile(11); send_tile(12); send_tile(131);
      drain();

      quiet = 1'b0;
      for (int phase = 0; phase < 40; phase++) begin
         random_grid();
         span = $urandom_range(1, 300);
         quiet = (phase >= 10 && phase < 14);
         repeat (42) send_tile(pick_tile(span));
         drain();
      end
      quiet = 1'b0;
      repeat (LATENCY + 20) @(posedge clock);

      $display("covered %0d requests and %0d responses over 49 grid settings", sent, rsp_seen);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: files.f
rtl/atuv_pkg.sv
rtl/atuv_if.sv
rtl/atuv_div_cell.sv
rtl/atuv_edge.sv
rtl/atlas_tile_uv_calc.sv
sim/atuv_uv_checker.sv
sim/atlas_tile_uv_calc_test.sv
